@@ hw/rtl/bpc_pkg.sv @@
// ----------------------------------------------------------------------------
// bpc_pkg
// shared types, constants and helpers for the pressure compensation pipeline
// ----------------------------------------------------------------------------
package bpc_pkg;

  localparam int unsigned WORD_W = 32;

  typedef logic [WORD_W-1:0] word_t;
  typedef logic [15:0]       half_t;

  // configuration register indexes
  localparam logic [2:0] REG_OVERSAMPLING = 3'd0;
  localparam logic [2:0] REG_COEF_GROUP_A = 3'd1;
  localparam logic [2:0] REG_COEF_GROUP_B = 3'd2;
  localparam logic [2:0] REG_COEF_B_PAIR  = 3'd3;
  localparam logic [2:0] REG_COEF_M_PAIR  = 3'd4;

  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 48;

  // compensation constants
  localparam word_t K_B6_OFS = 32'd4000;
  localparam word_t K_QUAD   = 32'd3038;
  localparam word_t K_LIN    = 32'hFFFF_E343;  // -7357
  localparam word_t K_CONST  = 32'd3791;
  localparam word_t K_B7     = 32'd50000;
  localparam word_t K_B4_OFS = 32'd32768;
  localparam word_t K_MMHG   = 32'd760;
  localparam word_t K_ATM    = 32'd101325;

  // reciprocal of 101325 scaled by 2^48, fits in 32 bits
  localparam logic [63:0] RECIP_FULL = (64'd1 << 48) / 64'd101325;
  localparam word_t       RECIP_ATM  = RECIP_FULL[31:0];

  function automatic word_t sx16(input half_t v);
    return {{16{v[15]}}, v};
  endfunction

  function automatic word_t zx16(input half_t v);
    return {16'h0000, v};
  endfunction

  // signed divide by 2^k, truncating toward zero, on a wrapped word
  function automatic word_t sdiv_p2(input word_t x, input int unsigned k);
    word_t mag;
    mag = x[WORD_W-1] ? (~x + 32'd1) : x;
    mag = mag >> k;
    return x[WORD_W-1] ? (~mag + 32'd1) : mag;
  endfunction

endpackage

@@ hw/rtl/bpc_if.sv @@
// ----------------------------------------------------------------------------
// bpc_if
// handshake channels of the pressure compensation block
// ----------------------------------------------------------------------------
interface bpc_in_if;
  logic        valid;
  logic        ready;
  logic [15:0] raw_temperature;
  logic [15:0] raw_pressure;
  modport source (output valid, raw_temperature, raw_pressure, input ready);
  modport sink   (input valid, raw_temperature, raw_pressure, output ready);
endinterface

interface bpc_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] pressure_pa;
  logic signed [31:0] pressure_mmhg;
  logic               divide_error;
  modport source (output valid, pressure_pa, pressure_mmhg, divide_error, input ready);
  modport sink   (input valid, pressure_pa, pressure_mmhg, divide_error, output ready);
endinterface

interface bpc_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [47:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

@@ hw/rtl/barometric_pressure_compensation_top.sv @@
// ----------------------------------------------------------------------------
// barometric_pressure_compensation_top
// fixed-point barometric pressure compensation, fully pipelined
// ----------------------------------------------------------------------------
// Takes one raw temperature / raw pressure item per cycle and returns the
// compensated pressure in pascal and in mmHg, with divide_error set (and
// both results zero) when the temperature or pressure divisor is zero.
// Throughput is one item per clock while the output is not stalled; an item
// passes 85 register stages before result valid rises. The depth is set by
// the two 32-stage bit-per-stage dividers plus 21 other register stages.
// The whole pipe advances on one enable, so a stall at the output freezes
// every stage and nothing is lost or repeated.
// Write configuration only while the pipe is empty; cfg.ready is always high
// and writes to unknown indexes are dropped.
module barometric_pressure_compensation_top (
  input  logic      clk,
  input  logic      rst,
  bpc_in_if.sink    sample,
  bpc_out_if.source result,
  bpc_cfg_if.sink   cfg
);
  import bpc_pkg::*;

  // configuration registers
  logic [1:0]  mode;
  logic [47:0] coef_a;
  logic [47:0] coef_b;
  logic [31:0] coef_bp;
  logic [31:0] coef_mp;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode    <= '0;
      coef_a  <= '0;
      coef_b  <= '0;
      coef_bp <= '0;
      coef_mp <= '0;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        REG_OVERSAMPLING: mode    <= cfg.data[1:0];
        REG_COEF_GROUP_A: coef_a  <= cfg.data;
        REG_COEF_GROUP_B: coef_b  <= cfg.data;
        REG_COEF_B_PAIR:  coef_bp <= cfg.data[31:0];
        REG_COEF_M_PAIR:  coef_mp <= cfg.data[31:0];
        default: ;
      endcase
    end
  end

  // calibration words as 32-bit values
  word_t ac1, ac2, ac3, ac4, ac5, ac6, b1, b2, mc, md;
  assign ac1 = sx16(coef_a[47:32]);
  assign ac2 = sx16(coef_a[31:16]);
  assign ac3 = sx16(coef_a[15:0]);
  assign ac4 = zx16(coef_b[47:32]);
  assign ac5 = zx16(coef_b[31:16]);
  assign ac6 = zx16(coef_b[15:0]);
  assign b1  = sx16(coef_bp[31:16]);
  assign b2  = sx16(coef_bp[15:0]);
  assign mc  = sx16(coef_mp[31:16]);
  assign md  = sx16(coef_mp[15:0]);

  // global pipe enable: hold everything while the output item waits
  logic o_valid;
  logic adv;
  assign adv          = !o_valid || result.ready;
  assign sample.ready = adv;

  // stage 1: temperature product
  logic  s1_v;
  word_t s1_t;
  half_t s1_up;
  // stage 2: x1 and temperature divisor
  logic  s2_v;
  word_t s2_x1, s2_den;
  half_t s2_up;
  // stage 4: b6
  logic  s4_v, s4_dz;
  word_t s4_b6;
  half_t s4_up;
  // stage 5: products of b6
  logic  s5_v, s5_dz;
  word_t s5_sq, s5_a2, s5_a3;
  half_t s5_up;
  // stage 6
  logic  s6_v, s6_dz;
  word_t s6_bsq, s6_x2a, s6_x1c;
  half_t s6_up;
  // stage 7
  logic  s7_v, s7_dz;
  word_t s7_m2, s7_m1, s7_x2a, s7_x1c;
  half_t s7_up;
  // stage 8
  logic  s8_v, s8_dz;
  word_t s8_x3, s8_sc;
  half_t s8_up;
  // stage 9: b3 and b4 factor
  logic  s9_v, s9_dz;
  word_t s9_b3, s9_t4;
  half_t s9_up;
  // stage 10: b4 and pressure difference
  logic  s10_v, s10_dz;
  word_t s10_b4, s10_diff;
  // stage 11: b7
  logic  s11_v, s11_err;
  word_t s11_b7, s11_b4;
  // stage 12 onward: pressure polynomial
  logic  s12_v, s12_err;
  word_t s12_p;
  logic  s13_v, s13_err;
  word_t s13_p, s13_xs, s13_y;
  logic  s14_v, s14_err;
  word_t s14_p, s14_sq, s14_x2;
  logic  s15_v, s15_err;
  word_t s15_p, s15_m, s15_x2;
  logic  s16_v, s16_err;
  word_t s16_p, s16_s;
  logic  s17_v, s17_err;
  word_t s17_p;
  // mmHg conversion by reciprocal multiply with one correction step
  logic  s18_v, s18_err;
  word_t s18_p, s18_pm;
  logic  s19_v, s19_err, s19_neg;
  word_t s19_p, s19_a;
  logic  s20_v, s20_err, s20_neg;
  word_t s20_p, s20_a;
  logic [63:0] s20_prod;
  logic  s21_v, s21_err, s21_neg;
  word_t s21_p, s21_a, s21_qd;
  half_t s21_q0;

  // output register
  word_t o_pa, o_mm;
  logic  o_err;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v <= 1'b0;
      s2_v <= 1'b0;
    end else if (adv) begin
      s1_v <= sample.valid;
      s2_v <= s1_v;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_t   <= (sx16(sample.raw_temperature) - ac6) * ac5;
      s1_up  <= sample.raw_pressure;
      s2_x1  <= sdiv_p2(s1_t, 15);
      s2_den <= sdiv_p2(s1_t, 15) + md;
      s2_up  <= s1_up;
    end
  end

  // first divider: mc * 2048 / (x1 + md), signed through magnitudes
  word_t d1_num_raw, d1_num, d1_den, d1_q;
  logic  d1_v;
  logic [49:0] d1_side_in, d1_side;
  assign d1_num_raw = mc << 11;
  assign d1_num     = d1_num_raw[31] ? (~d1_num_raw + 32'd1) : d1_num_raw;
  assign d1_den     = s2_den[31] ? (~s2_den + 32'd1) : s2_den;
  assign d1_side_in = {s2_x1, s2_up, d1_num_raw[31] ^ s2_den[31], s2_den == '0};

  bpc_div #(.PW(50)) u_div_temp (
    .clk      (clk),
    .rst      (rst),
    .en       (adv),
    .in_valid (s2_v),
    .num      (d1_num),
    .den      (d1_den),
    .side_in  (d1_side_in),
    .out_valid(d1_v),
    .quo      (d1_q),
    .side_out (d1_side)
  );

  word_t d1_x2;
  assign d1_x2 = d1_side[1] ? (~d1_q + 32'd1) : d1_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      s4_v  <= 1'b0;
      s5_v  <= 1'b0;
      s6_v  <= 1'b0;
      s7_v  <= 1'b0;
      s8_v  <= 1'b0;
      s9_v  <= 1'b0;
      s10_v <= 1'b0;
      s11_v <= 1'b0;
    end else if (adv) begin
      s4_v  <= d1_v;
      s5_v  <= s4_v;
      s6_v  <= s5_v;
      s7_v  <= s6_v;
      s8_v  <= s7_v;
      s9_v  <= s8_v;
      s10_v <= s9_v;
      s11_v <= s10_v;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      // b6 = x1 + x2 - 4000
      s4_b6  <= d1_side[49:18] + d1_x2 - K_B6_OFS;
      s4_up  <= d1_side[17:2];
      s4_dz  <= d1_side[0];

      s5_sq  <= s4_b6 * s4_b6;
      s5_a2  <= ac2 * s4_b6;
      s5_a3  <= ac3 * s4_b6;
      s5_up  <= s4_up;
      s5_dz  <= s4_dz;

      s6_bsq <= sdiv_p2(s5_sq, 12);
      s6_x2a <= sdiv_p2(s5_a2, 11);
      s6_x1c <= sdiv_p2(s5_a3, 13);
      s6_up  <= s5_up;
      s6_dz  <= s5_dz;

      s7_m2  <= b2 * s6_bsq;
      s7_m1  <= b1 * s6_bsq;
      s7_x2a <= s6_x2a;
      s7_x1c <= s6_x1c;
      s7_up  <= s6_up;
      s7_dz  <= s6_dz;

      s8_x3  <= sdiv_p2(s7_m2, 11) + s7_x2a;
      s8_sc  <= s7_x1c + sdiv_p2(s7_m1, 16) + 32'd2;
      s8_up  <= s7_up;
      s8_dz  <= s7_dz;

      // b3 = (((ac1 * 4 + x3) << mode) + 2) / 4
      s9_b3  <= sdiv_p2((((ac1 << 2) + s8_x3) << mode) + 32'd2, 2);
      s9_t4  <= sdiv_p2(s8_sc, 2) + K_B4_OFS;
      s9_up  <= s8_up;
      s9_dz  <= s8_dz;

      s10_b4   <= word_t'(ac4 * s9_t4) >> 15;
      s10_diff <= zx16(s9_up) - s9_b3;
      s10_dz   <= s9_dz;

      s11_b7  <= s10_diff * (K_B7 >> mode);
      s11_b4  <= s10_b4;
      s11_err <= s10_dz || (s10_b4 == '0);
    end
  end

  // second divider: b7 / b4 unsigned; double before or after by b7's top bit
  word_t d2_num, d2_q;
  logic  d2_v;
  logic [1:0] d2_side;
  assign d2_num = s11_b7[31] ? s11_b7 : (s11_b7 << 1);

  bpc_div #(.PW(2)) u_div_press (
    .clk      (clk),
    .rst      (rst),
    .en       (adv),
    .in_valid (s11_v),
    .num      (d2_num),
    .den      (s11_b4),
    .side_in  ({s11_b7[31], s11_err}),
    .out_valid(d2_v),
    .quo      (d2_q),
    .side_out (d2_side)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s12_v   <= 1'b0;
      s13_v   <= 1'b0;
      s14_v   <= 1'b0;
      s15_v   <= 1'b0;
      s16_v   <= 1'b0;
      s17_v   <= 1'b0;
      s18_v   <= 1'b0;
      s19_v   <= 1'b0;
      s20_v   <= 1'b0;
      s21_v   <= 1'b0;
      o_valid <= 1'b0;
    end else if (adv) begin
      s12_v   <= d2_v;
      s13_v   <= s12_v;
      s14_v   <= s13_v;
      s15_v   <= s14_v;
      s16_v   <= s15_v;
      s17_v   <= s16_v;
      s18_v   <= s17_v;
      s19_v   <= s18_v;
      s20_v   <= s19_v;
      s21_v   <= s20_v;
      o_valid <= s21_v;
    end
  end

  // final quotient correction
  word_t r_fix, q_fix, mm_fix;
  assign r_fix  = s21_a - s21_qd;
  assign q_fix  = zx16(s21_q0) + ((r_fix >= K_ATM) ? 32'd1 : 32'd0);
  assign mm_fix = s21_neg ? (~q_fix + 32'd1) : q_fix;

  always_ff @(posedge clk) begin
    if (adv) begin
      s12_p   <= d2_side[1] ? (d2_q << 1) : d2_q;
      s12_err <= d2_side[0];

      s13_xs  <= sdiv_p2(s12_p, 8);
      s13_y   <= K_LIN * s12_p;
      s13_p   <= s12_p;
      s13_err <= s12_err;

      s14_sq  <= s13_xs * s13_xs;
      s14_x2  <= sdiv_p2(s13_y, 16);
      s14_p   <= s13_p;
      s14_err <= s13_err;

      s15_m   <= s14_sq * K_QUAD;
      s15_x2  <= s14_x2;
      s15_p   <= s14_p;
      s15_err <= s14_err;

      s16_s   <= sdiv_p2(s15_m, 16) + s15_x2 + K_CONST;
      s16_p   <= s15_p;
      s16_err <= s15_err;

      s17_p   <= s16_p + sdiv_p2(s16_s, 4);
      s17_err <= s16_err;

      s18_pm  <= s17_p * K_MMHG;
      s18_p   <= s17_p;
      s18_err <= s17_err;

      s19_a   <= s18_pm[31] ? (~s18_pm + 32'd1) : s18_pm;
      s19_neg <= s18_pm[31];
      s19_p   <= s18_p;
      s19_err <= s18_err;

      s20_prod <= {32'h0, s19_a} * {32'h0, RECIP_ATM};
      s20_a    <= s19_a;
      s20_neg  <= s19_neg;
      s20_p    <= s19_p;
      s20_err  <= s19_err;

      s21_q0  <= s20_prod[63:48];
      s21_qd  <= zx16(s20_prod[63:48]) * K_ATM;
      s21_a   <= s20_a;
      s21_neg <= s20_neg;
      s21_p   <= s20_p;
      s21_err <= s20_err;

      o_pa  <= s21_err ? '0 : s21_p;
      o_mm  <= s21_err ? '0 : mm_fix;
      o_err <= s21_err;
    end
  end

  assign result.valid         = o_valid;
  assign result.pressure_pa   = o_pa;
  assign result.pressure_mmhg = o_mm;
  assign result.divide_error  = o_err;

  // an error item always carries zero results
  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    result.valid && result.divide_error |-> o_pa == '0 && o_mm == '0)
    else $error("error item with nonzero results");

  // reciprocal estimate is never more than one below the true quotient
  a_recip_close: assert property (@(posedge clk) disable iff (rst)
    s21_v |-> r_fix < (K_ATM << 1))
    else $error("mmhg quotient estimate off by more than one");

  // pipe comes out of reset empty
  a_reset_empty: assert property (@(posedge clk) disable iff (rst)
    $past(rst) |-> !result.valid)
    else $error("result valid right after reset");

endmodule

@@ hw/rtl/bpc_div.sv @@
// ----------------------------------------------------------------------------
// bpc_div
// pipelined unsigned 32/32 restoring divider, one quotient bit per stage
// ----------------------------------------------------------------------------
module bpc_div #(
  parameter int unsigned PW = 1
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 en,
  input  logic                 in_valid,
  input  bpc_pkg::word_t       num,
  input  bpc_pkg::word_t       den,
  input  logic [PW-1:0]        side_in,
  output logic                 out_valid,
  output bpc_pkg::word_t       quo,
  output logic [PW-1:0]        side_out
);
  import bpc_pkg::*;

  localparam int unsigned N = WORD_W;

  word_t         rem  [1:N];
  word_t         nq   [1:N];  // numerator bits out at the top, quotient bits in
  word_t         dv   [1:N];
  logic [PW-1:0] side [1:N];
  logic          vld  [1:N];

  for (genvar i = 1; i <= N; i++) begin : g_stage
    word_t         rem_in;
    word_t         nq_in;
    word_t         dv_in;
    logic [PW-1:0] side_prev;
    logic          vld_in;
    logic [N:0]    trial;
    logic          ge;

    if (i == 1) begin : g_first
      assign rem_in    = '0;
      assign nq_in     = num;
      assign dv_in     = den;
      assign side_prev = side_in;
      assign vld_in    = in_valid;
    end else begin : g_rest
      assign rem_in    = rem[i-1];
      assign nq_in     = nq[i-1];
      assign dv_in     = dv[i-1];
      assign side_prev = side[i-1];
      assign vld_in    = vld[i-1];
    end

    assign trial = {rem_in, nq_in[N-1]};
    assign ge    = trial >= {1'b0, dv_in};

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[i] <= 1'b0;
      end else if (en) begin
        vld[i] <= vld_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem[i]  <= ge ? N'(trial - {1'b0, dv_in}) : trial[N-1:0];
        nq[i]   <= {nq_in[N-2:0], ge};
        dv[i]   <= dv_in;
        side[i] <= side_prev;
      end
    end
  end

  assign out_valid = vld[N];
  assign quo       = nq[N];
  assign side_out  = side[N];

endmodule
